[rtl/nnva_pkg.sv]
// Shared types and constants for the nearest-note voice allocator.
package nnva_pkg;

   localparam int MAX_VOICES = 64;
   localparam int VOICE_W    = $clog2(MAX_VOICES);
   localparam int COUNT_W    = $clog2(MAX_VOICES + 1);
   localparam int NOTE_W     = 7;
   localparam int CFG_W      = 7;

   localparam logic [NOTE_W-1:0]  NEAR_LIMIT = 7'd100;
   localparam logic [COUNT_W-1:0] VOICE_CAP  = COUNT_W'(MAX_VOICES);

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_FINISHED = 2'd2;

   localparam logic [1:0] ST_IGNORED  = 2'd0;
   localparam logic [1:0] ST_STARTED  = 2'd1;
   localparam logic [1:0] ST_RELEASED = 2'd2;
   localparam logic [1:0] ST_FREED    = 2'd3;

   localparam logic CSR_LISTEN_CHANNEL = 1'b0;
   localparam logic CSR_VOICE_LIMIT    = 1'b1;

   typedef enum logic [1:0] {
      CMD_IGNORE,
      CMD_ON,
      CMD_OFF,
      CMD_FREE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [NOTE_W-1:0]   key;
      logic [NOTE_W-1:0]   strike;
      logic [VOICE_W-1:0]  vid;
      logic [COUNT_W-1:0]  count;
   } cmd_type;

   typedef enum logic [1:0] {
      ENG_IDLE,
      ENG_SCAN,
      ENG_WAIT,
      ENG_DONE
   } eng_state_type;

endpackage

[rtl/nearest_note_voice_allocator.sv]
// Nearest-note voice allocator: front end, command queue and voice engine.
// Each accepted event walks n voices, n being min(voice_limit, 64) for note on and
//   note off and 1 for voice finished, before its result word is registered; ignored
//   events and a zero limit skip the walk. One event is worked on while the queue holds
//   two more; an untaken result word holds the engine. Reset (synchronous, active high)
//   clears all voices, gates and notes and sets the channel to omni and the polyphony to 64.
module nearest_note_voice_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [nnva_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [3:0]                    req_channel,
   input  logic [nnva_pkg::NOTE_W-1:0]   req_key,
   input  logic [nnva_pkg::NOTE_W-1:0]   req_strike,
   input  logic [nnva_pkg::VOICE_W-1:0]  req_voice_id,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [nnva_pkg::VOICE_W-1:0]  rsp_voice_index,
   output logic [nnva_pkg::NOTE_W-1:0]   rsp_voice_key,
   output logic [nnva_pkg::NOTE_W-1:0]   rsp_voice_strike,
   output logic                          rsp_was_busy,
   output logic [nnva_pkg::MAX_VOICES-1:0] rsp_released_mask
);
   import nnva_pkg::*;

   cmd_type push_cmd, pop_cmd;
   logic    q_full, q_push, q_pop, q_valid;

   nnva_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_channel  (req_channel),
      .req_key      (req_key),
      .req_strike   (req_strike),
      .req_voice_id (req_voice_id),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_cmd        (push_cmd)
   );

   nnva_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (pop_cmd)
   );

   nnva_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (pop_cmd),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_voice_index   (rsp_voice_index),
      .rsp_voice_key     (rsp_voice_key),
      .rsp_voice_strike  (rsp_voice_strike),
      .rsp_was_busy      (rsp_was_busy),
      .rsp_released_mask (rsp_released_mask)
   );

`ifndef SYNTHESIS
   a_mask_only_on_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_RELEASED |-> rsp_released_mask == '0)
      else $error("released mask set on a word that releases nothing");

   a_busy_only_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_busy |-> rsp_status == ST_STARTED)
      else $error("steal flag on a word that starts no voice");

   a_ignored_is_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_IGNORED |->
         rsp_voice_index == '0 && rsp_voice_key == '0 && rsp_voice_strike == '0)
      else $error("ignored event carries voice data");

   a_started_has_strike: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_STARTED |-> rsp_voice_strike != '0)
      else $error("voice started with zero velocity");
`endif

endmodule

[rtl/nnva_front.sv]
// Front end: configuration registers and event classification.
module nnva_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [nnva_pkg::CFG_W-1:0]    csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [3:0]                    req_channel,
   input  logic [nnva_pkg::NOTE_W-1:0]   req_key,
   input  logic [nnva_pkg::NOTE_W-1:0]   req_strike,
   input  logic [nnva_pkg::VOICE_W-1:0]  req_voice_id,
   input  logic                          q_full,
   output logic                          q_push,
   output nnva_pkg::cmd_type             q_cmd
);
   import nnva_pkg::*;

   logic [4:0]       listen_ff, listen_in;
   logic [CFG_W-1:0] limit_ff, limit_in;
   logic             chan_ok;
   logic             is_off;

   always_comb begin
      listen_in = listen_ff;
      limit_in  = limit_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_LISTEN_CHANNEL: listen_in = csr_wdata[4:0];
            CSR_VOICE_LIMIT:    limit_in  = csr_wdata;
            default:            listen_in = listen_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff <= 5'h1F;
         limit_ff  <= CFG_W'(MAX_VOICES);
      end else begin
         listen_ff <= listen_in;
         limit_ff  <= limit_in;
      end
   end

   // negative channel register means omni
   assign chan_ok = listen_ff[4] || (listen_ff[3:0] == req_channel);
   // note on with zero velocity acts as note off
   assign is_off  = (req_op == OP_NOTE_OFF) ||
                    (req_op == OP_NOTE_ON && req_strike == '0);

   always_comb begin
      q_cmd.key    = req_key;
      q_cmd.strike = req_strike;
      q_cmd.vid    = req_voice_id;
      q_cmd.count  = (limit_ff > CFG_W'(MAX_VOICES)) ? VOICE_CAP : COUNT_W'(limit_ff);
      if (is_off) begin
         q_cmd.kind = chan_ok ? CMD_OFF : CMD_IGNORE;
      end else begin
         unique case (req_op)
            OP_NOTE_ON:  q_cmd.kind = chan_ok ? CMD_ON : CMD_IGNORE;
            OP_FINISHED: q_cmd.kind = CMD_FREE;
            default:     q_cmd.kind = CMD_IGNORE;
         endcase
      end
   end

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

endmodule

[rtl/nnva_queue.sv]
// Two-entry command queue between front end and voice engine.
module nnva_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nnva_pkg::cmd_type  push_cmd,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output nnva_pkg::cmd_type  pop_cmd
);
   import nnva_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full      = (cnt_ff == 2'd2);
   assign pop_valid = (cnt_ff != 2'd0);
   assign pop_cmd   = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/nnva_engine.sv]
// Voice engine: walks the voice table one voice a cycle and commits each command.
module nnva_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   input  nnva_pkg::cmd_type             q_cmd,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [nnva_pkg::VOICE_W-1:0]  rsp_voice_index,
   output logic [nnva_pkg::NOTE_W-1:0]   rsp_voice_key,
   output logic [nnva_pkg::NOTE_W-1:0]   rsp_voice_strike,
   output logic                          rsp_was_busy,
   output logic [nnva_pkg::MAX_VOICES-1:0] rsp_released_mask
);
   import nnva_pkg::*;

   eng_state_type state_ff, state_in;
   cmd_type       cmd_ff;

   logic [NOTE_W-1:0]     note_mem [MAX_VOICES];
   logic [MAX_VOICES-1:0] written_ff, written_in;
   logic [MAX_VOICES-1:0] gate_ff, gate_in;
   logic [MAX_VOICES-1:0] active_ff, active_in;

   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic                  rd_vld_ff;
   logic [VOICE_W-1:0]    rd_idx_ff;
   logic [NOTE_W-1:0]     rd_data_ff;

   logic [NOTE_W-1:0]     best_ff, best_in;
   logic [VOICE_W-1:0]    pick_ff, pick_in;
   logic [MAX_VOICES-1:0] mask_ff, mask_in;
   logic [NOTE_W-1:0]     free_note_ff, free_note_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            status_ff;
   logic [VOICE_W-1:0]    index_ff;
   logic [NOTE_W-1:0]     key_ff;
   logic [NOTE_W-1:0]     strike_ff;
   logic                  busy_ff;
   logic [MAX_VOICES-1:0] rmask_ff;

   logic [1:0]            res_status;
   logic [VOICE_W-1:0]    res_index;
   logic [NOTE_W-1:0]     res_key;
   logic [NOTE_W-1:0]     res_strike;
   logic                  res_busy;
   logic [MAX_VOICES-1:0] res_mask;

   logic                  rd_en, commit, out_free, scan_last, direct;
   logic [NOTE_W-1:0]     note_v, note_gap;
   logic                  free_fit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign scan_last = (cmd_ff.kind == CMD_FREE) || ((cnt_ff + COUNT_W'(1)) == cmd_ff.count);
   assign direct    = (q_cmd.kind == CMD_IGNORE) ||
                      (q_cmd.kind != CMD_FREE && q_cmd.count == '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_IDLE: if (q_valid) state_in = direct ? ENG_DONE : ENG_SCAN;
         ENG_SCAN: if (scan_last) state_in = ENG_WAIT;
         ENG_WAIT: state_in = ENG_DONE;
         ENG_DONE: if (out_free) state_in = ENG_IDLE;
         default:  state_in = ENG_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop  = 1'b0;
      rd_en  = 1'b0;
      commit = 1'b0;
      unique case (state_ff)
         ENG_IDLE: q_pop  = q_valid;
         ENG_SCAN: rd_en  = 1'b1;
         ENG_WAIT: q_pop  = 1'b0;
         ENG_DONE: commit = out_free;
         default:  q_pop  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ENG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // note memory, one read a cycle during the walk
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= note_mem[cnt_ff[VOICE_W-1:0]];
      end
      if (commit && cmd_ff.kind == CMD_ON) begin
         note_mem[pick_ff] <= cmd_ff.key;
      end
   end

   // compare stage on the registered read
   assign note_v   = written_ff[rd_idx_ff] ? rd_data_ff : '0;
   assign note_gap = (note_v >= cmd_ff.key) ? (note_v - cmd_ff.key) : (cmd_ff.key - note_v);
   assign free_fit = ({1'b0, cmd_ff.vid} < cmd_ff.count) &&
                     active_ff[cmd_ff.vid] && !gate_ff[cmd_ff.vid];

   always_comb begin
      cnt_in       = cnt_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      mask_in      = mask_ff;
      free_note_in = free_note_ff;
      written_in   = written_ff;
      gate_in      = gate_ff;
      active_in    = active_ff;
      if (q_pop) begin
         cnt_in       = (q_cmd.kind == CMD_FREE) ? {1'b0, q_cmd.vid} : '0;
         best_in      = NEAR_LIMIT;
         pick_in      = '0;
         mask_in      = '0;
         free_note_in = '0;
      end
      if (rd_en) begin
         cnt_in = cnt_ff + COUNT_W'(1);
      end
      if (rd_vld_ff) begin
         unique case (cmd_ff.kind)
            CMD_ON: begin
               if (!active_ff[rd_idx_ff] && note_gap < best_ff) begin
                  pick_in = rd_idx_ff;
                  best_in = note_gap;
               end
            end
            CMD_OFF: begin
               if (gate_ff[rd_idx_ff] && active_ff[rd_idx_ff] && note_v == cmd_ff.key) begin
                  gate_in[rd_idx_ff] = 1'b0;
                  mask_in[rd_idx_ff] = 1'b1;
               end
            end
            CMD_FREE:   free_note_in = note_v;
            CMD_IGNORE: free_note_in = free_note_ff;
            default:    free_note_in = free_note_ff;
         endcase
      end
      if (commit) begin
         if (cmd_ff.kind == CMD_ON) begin
            written_in[pick_ff] = 1'b1;
            gate_in[pick_ff]    = 1'b1;
            active_in[pick_ff]  = 1'b1;
         end else if (cmd_ff.kind == CMD_FREE && free_fit) begin
            active_in[cmd_ff.vid] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff  <= 1'b0;
         written_ff <= '0;
         gate_ff    <= '0;
         active_ff  <= '0;
      end else begin
         rd_vld_ff  <= rd_en;
         written_ff <= written_in;
         gate_ff    <= gate_in;
         active_ff  <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_cmd;
      end
      rd_idx_ff    <= cnt_ff[VOICE_W-1:0];
      cnt_ff       <= cnt_in;
      best_ff      <= best_in;
      pick_ff      <= pick_in;
      mask_ff      <= mask_in;
      free_note_ff <= free_note_in;
   end

   // result word
   always_comb begin
      res_status = ST_IGNORED;
      res_index  = '0;
      res_key    = '0;
      res_strike = '0;
      res_busy   = 1'b0;
      res_mask   = '0;
      unique case (cmd_ff.kind)
         CMD_ON: begin
            res_status = ST_STARTED;
            res_index  = pick_ff;
            res_key    = cmd_ff.key;
            res_strike = cmd_ff.strike;
            res_busy   = active_ff[pick_ff];
         end
         CMD_OFF: begin
            res_status = ST_RELEASED;
            res_mask   = mask_ff;
         end
         CMD_FREE: begin
            if (free_fit) begin
               res_status = ST_FREED;
               res_index  = cmd_ff.vid;
               res_key    = free_note_ff;
            end
         end
         CMD_IGNORE: res_status = ST_IGNORED;
         default:    res_status = ST_IGNORED;
      endcase
   end

   // hold the word until taken
   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff <= res_status;
         index_ff  <= res_index;
         key_ff    <= res_key;
         strike_ff <= res_strike;
         busy_ff   <= res_busy;
         rmask_ff  <= res_mask;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_voice_index   = index_ff;
   assign rsp_voice_key     = key_ff;
   assign rsp_voice_strike  = strike_ff;
   assign rsp_was_busy      = busy_ff;
   assign rsp_released_mask = rmask_ff;

endmodule
